// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// ===== hw/rtl/rmfh_pkg.sv =====
// ---------------------------------------------------------------------------
// rmfh_pkg
// types, status codes and defaults of the recursive mutex lock unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmfh_pkg;

  // default sizing
  localparam int MAX_TASKS_DEF = 16;
  localparam int COUNT_MAX_DEF = 255;

  // fixed field widths
  localparam int TASK_W   = 4;
  localparam int STATUS_W = 3;
  localparam int HOLD_W   = 8;

  typedef logic [TASK_W-1:0]   task_t;
  typedef logic [STATUS_W-1:0] status_t;

  // operation codes
  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  // status codes
  localparam status_t ST_ACQUIRED  = 3'd0;
  localparam status_t ST_NESTED    = 3'd1;
  localparam status_t ST_BLOCKED   = 3'd2;
  localparam status_t ST_PARTIAL   = 3'd3;
  localparam status_t ST_FREED     = 3'd4;
  localparam status_t ST_HANDOFF   = 3'd5;
  localparam status_t ST_NOT_OWNER = 3'd6;
  localparam status_t ST_OVERFLOW  = 3'd7;

  // request word
  typedef struct packed {
    logic  operation;
    task_t task_id;
  } req_t;

  // result word
  typedef struct packed {
    status_t           status;
    logic              woken_valid;
    task_t             woken_task;
    logic              owner_valid;
    task_t             owner_task;
    logic [HOLD_W-1:0] hold_count;
  } rsp_t;

  // wait queue write control
  typedef struct packed {
    logic  en;
    task_t data;
  } qwr_t;

endpackage

// ===== hw/rtl/rmfh_qmem.sv =====
// ---------------------------------------------------------------------------
// rmfh_qmem
// wait queue storage, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmfh_qmem #(
  parameter int DEPTH = rmfh_pkg::MAX_TASKS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  rmfh_pkg::qwr_t  wr,
  input  logic [AW-1:0]   wr_addr,
  input  logic [AW-1:0]   rd_addr,
  output rmfh_pkg::task_t rd_data
);

  rmfh_pkg::task_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/rmfh_core.sv =====
// ---------------------------------------------------------------------------
// rmfh_core
// lock owner, nesting count and queue pointers; decides each request
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmfh_core #(
  parameter int MAX_TASKS = rmfh_pkg::MAX_TASKS_DEF,
  parameter int COUNT_MAX = rmfh_pkg::COUNT_MAX_DEF,
  parameter int PW        = $clog2(MAX_TASKS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            exec,
  input  rmfh_pkg::req_t  req,
  input  rmfh_pkg::task_t rd_data,
  output logic [PW-1:0]   head,
  output logic [PW-1:0]   tail,
  output rmfh_pkg::qwr_t  qwr,
  output rmfh_pkg::rsp_t  rsp
);

  localparam int CW = $clog2(COUNT_MAX + 1);
  localparam int FW = $clog2(MAX_TASKS + 1);
  localparam int HW = rmfh_pkg::HOLD_W;

  logic                  held, held_next;
  rmfh_pkg::task_t       owner, owner_next;
  logic [CW-1:0]         count, count_next;
  logic [PW-1:0]         head_next, tail_next;
  logic [FW-1:0]         fill, fill_next;
  logic [CW-1:0]         count_dec;
  logic                  is_owner;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == PW'(MAX_TASKS - 1)) ? '0 : p + PW'(1);
  endfunction

  assign is_owner  = held && (owner == req.task_id);
  assign count_dec = count - CW'(1);

  // request decision
  always_comb begin
    held_next       = held;
    owner_next      = owner;
    count_next      = count;
    head_next       = head;
    tail_next       = tail;
    fill_next       = fill;
    qwr.en          = 1'b0;
    qwr.data        = req.task_id;
    rsp.woken_valid = 1'b0;
    rsp.woken_task  = '0;
    rsp.status      = rmfh_pkg::ST_NOT_OWNER;
    if (req.operation == rmfh_pkg::OP_LOCK) begin
      if (!held) begin
        held_next  = 1'b1;
        owner_next = req.task_id;
        count_next = CW'(1);
        rsp.status = rmfh_pkg::ST_ACQUIRED;
      end else if (is_owner) begin
        if (count >= CW'(COUNT_MAX)) begin
          rsp.status = rmfh_pkg::ST_OVERFLOW;
        end else begin
          count_next = count + CW'(1);
          rsp.status = rmfh_pkg::ST_NESTED;
        end
      end else if (fill >= FW'(MAX_TASKS)) begin
        rsp.status = rmfh_pkg::ST_OVERFLOW;
      end else begin
        qwr.en     = exec;
        tail_next  = next_slot(tail);
        fill_next  = fill + FW'(1);
        rsp.status = rmfh_pkg::ST_BLOCKED;
      end
    end else if (is_owner) begin
      count_next = count_dec;
      if (count_dec != '0) begin
        rsp.status = rmfh_pkg::ST_PARTIAL;
      end else if (fill != '0) begin
        // hand the lock to the head waiter
        rsp.woken_valid = 1'b1;
        rsp.woken_task  = rd_data;
        head_next       = next_slot(head);
        fill_next       = fill - FW'(1);
        owner_next      = rd_data;
        count_next      = CW'(1);
        rsp.status      = rmfh_pkg::ST_HANDOFF;
      end else begin
        held_next  = 1'b0;
        owner_next = '0;
        count_next = '0;
        rsp.status = rmfh_pkg::ST_FREED;
      end
    end
    // owner view after the request
    rsp.owner_valid = held_next;
    rsp.owner_task  = held_next ? owner_next : '0;
    rsp.hold_count  = held_next ? HW'(count_next) : '0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      owner <= '0;
      count <= '0;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else if (exec) begin
      held  <= held_next;
      owner <= owner_next;
      count <= count_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
    end
  end

  `ASSERT_NEVER(a_fill_bound, clk, rst, fill > FW'(MAX_TASKS), "queue fill beyond depth")
  `ASSERT_NEVER(a_free_clean, clk, rst, !held && (count != '0 || owner != '0),
                "free lock keeps owner or count")
  `ASSERT_PROP(a_handoff_pop, clk, rst,
               (exec && rsp.status == rmfh_pkg::ST_HANDOFF) |=> fill == $past(fill) - FW'(1),
               "handoff did not pop the queue")

endmodule

// ===== hw/rtl/recursive_mutex_fifo_handoff_top.sv =====
// Timing: a request accepted in the idle state is captured in req_q and decided in the exec
//   state; its result word is then registered on rsp, marked by done.
// No new request is taken while busy in the decide cycle; the head entry of the wait queue memory is
//   read in the accept cycle and used in the following decide cycle.
// Reset: rst frees the lock and empties the queue at once; queue memory is not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
// ---------------------------------------------------------------------------
// recursive_mutex_fifo_handoff_top
// recursive mutex lock unit with a fifo wait queue and handoff on release
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module recursive_mutex_fifo_handoff_top #(
  parameter int MAX_TASKS = rmfh_pkg::MAX_TASKS_DEF,
  parameter int COUNT_MAX = rmfh_pkg::COUNT_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  rmfh_pkg::req_t req,
  output logic           done,
  output rmfh_pkg::rsp_t rsp
);

  localparam int PW = $clog2(MAX_TASKS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic            state, state_next;
  logic            exec;
  rmfh_pkg::req_t  req_q;
  rmfh_pkg::task_t rd_data;
  logic [PW-1:0]   head, tail;
  rmfh_pkg::qwr_t  qwr;
  rmfh_pkg::rsp_t  core_rsp;

  assign busy = (state == S_EXEC);
  assign exec = (state == S_EXEC);

  // sequencer: accept, then decide
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec;
    end
  end

  // request and result words
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    if (exec) begin
      rsp <= core_rsp;
    end
  end

  rmfh_qmem #(
    .DEPTH (MAX_TASKS),
    .AW    (PW)
  ) u_qmem (
    .clk     (clk),
    .wr      (qwr),
    .wr_addr (tail),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  rmfh_core #(
    .MAX_TASKS (MAX_TASKS),
    .COUNT_MAX (COUNT_MAX),
    .PW        (PW)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .exec    (exec),
    .req     (req_q),
    .rd_data (rd_data),
    .head    (head),
    .tail    (tail),
    .qwr     (qwr),
    .rsp     (core_rsp)
  );

  `ASSERT_PROP(a_done_after_exec, clk, rst, done |-> $past(state == S_EXEC),
               "result strobe without a decide cycle")
  `ASSERT_PROP(a_accept_to_exec, clk, rst, (start && !busy) |=> busy,
               "accepted request did not enter decide cycle")
  `ASSERT_NEVER(a_done_not_busy, clk, rst, done && busy, "strobe while busy")

endmodule
